// ===== rtl/stok_pkg.sv =====
// Package for the source tokenizer: scan modes, token kinds, error codes,
// byte constants and byte classification functions. No dependencies.
package stok_pkg;

  typedef enum logic [3:0] {
    M_IDLE,
    M_NUM,
    M_IDENT,
    M_OP,
    M_CHAR_BODY,
    M_CHAR_CLOSE,
    M_STR,
    M_COMMENT,
    M_DRAIN
  } mode_t;

  localparam int KIND_W      = 6;
  localparam int BYTE_W      = 8;
  localparam int ERR_W       = 2;
  localparam int COUNT_W     = 2;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] K_NONE     = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMBER   = 6'd0;
  localparam logic [KIND_W-1:0] K_FLOAT    = 6'd1;
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd2;
  localparam logic [KIND_W-1:0] K_CHAR     = 6'd3;
  localparam logic [KIND_W-1:0] K_STRING   = 6'd4;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd5;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd7;
  localparam logic [KIND_W-1:0] K_MINUS_EQ = 6'd8;
  localparam logic [KIND_W-1:0] K_ARROW    = 6'd9;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd10;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd12;
  localparam logic [KIND_W-1:0] K_PERCENT  = 6'd14;
  localparam logic [KIND_W-1:0] K_LT       = 6'd16;
  localparam logic [KIND_W-1:0] K_GT       = 6'd18;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd20;
  localparam logic [KIND_W-1:0] K_BANG     = 6'd22;
  localparam logic [KIND_W-1:0] K_DOT      = 6'd24;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd25;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd26;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd27;
  localparam logic [KIND_W-1:0] K_AMP      = 6'd28;
  localparam logic [KIND_W-1:0] K_PIPE     = 6'd29;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd30;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd31;
  localparam logic [KIND_W-1:0] K_LBRACK   = 6'd32;
  localparam logic [KIND_W-1:0] K_RBRACK   = 6'd33;
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd34;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd35;
  localparam logic [KIND_W-1:0] K_BSLASH   = 6'd36;
  localparam logic [KIND_W-1:0] K_END      = 6'd37;

  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_QUOTE  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STRING = 2'd2;
  localparam logic [ERR_W-1:0] ERR_CHAR   = 2'd3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
  localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_US    = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_LBRC  = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_RBRC  = 8'h7D;

  function automatic logic is_numeral(input logic [BYTE_W-1:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return ((b >= CH_LC_A) && (b <= CH_LC_Z)) || ((b >= CH_UC_A) && (b <= CH_UC_Z)) ||
           (b == CH_US);
  endfunction

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [BYTE_W-1:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      CH_SLASH: k = K_SLASH;
      CH_PCT:   k = K_PERCENT;
      CH_LT:    k = K_LT;
      CH_GT:    k = K_GT;
      CH_EQ:    k = K_ASSIGN;
      CH_BANG:  k = K_BANG;
      default:  k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      CH_DOT:   k = K_DOT;
      CH_COMMA: k = K_COMMA;
      CH_COLON: k = K_COLON;
      CH_SEMI:  k = K_SEMI;
      CH_AMP:   k = K_AMP;
      CH_PIPE:  k = K_PIPE;
      CH_LBRC:  k = K_LBRACE;
      CH_RBRC:  k = K_RBRACE;
      CH_LBRK:  k = K_LBRACK;
      CH_RBRK:  k = K_RBRACK;
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_BSL:   k = K_BSLASH;
      default:  k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/source_tokenizer.sv =====
// Source tokenizer top level: front end, bundle queue and back end.
// Depends on stok_pkg, stok_front, stok_queue and stok_back.
//
// Input channel: drive byte_value and end_of_text with push; a byte transfers
// on a clock edge with push high and full low. end_of_text marks the last
// byte of a text; the scan state then returns to its reset values.
// Result channel: while empty is low the oldest token is on the result ports;
// it transfers on an edge with pop high. last_of_run flags the final token
// caused by one input byte.
// Each byte is classified in the cycle it transfers; its results, if any
// (at most three), are written into a four-entry queue as one bundle and
// reach the result ports from its head. Input runs at one byte per cycle
// while the queue has room; the back end delivers one token per cycle while
// pop is high, so bytes that yield several tokens drain at that rate.
// When pop stays low the queue fills and full rises; nothing is lost.
// Synchronous reset clears the scan state and empties the queue.
module source_tokenizer
  import stok_pkg::*;
#(
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS = 16,
  parameter int INDENT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [BYTE_W-1:0]        byte_value,
  input  logic                     end_of_text,
  output logic                     empty,
  input  logic                     pop,
  output logic [KIND_W-1:0]        token_kind,
  output logic [LINE_BITS-1:0]     line_number,
  output logic [INDENT_BITS-1:0]   indent,
  output logic [POSITION_BITS-1:0] start_offset,
  output logic [POSITION_BITS-1:0] text_length,
  output logic [BYTE_W-1:0]        char_value,
  output logic [ERR_W-1:0]         error_code,
  output logic                     last_of_run
);

  localparam int REC_W = KIND_W + LINE_BITS + INDENT_BITS + 2 * POSITION_BITS + BYTE_W + ERR_W;
  localparam int BUNDLE_W = COUNT_W + MAX_RESULTS * REC_W;

  logic                accept;
  logic                bundle_valid;
  logic [BUNDLE_W-1:0] bundle;
  logic [BUNDLE_W-1:0] head;
  logic                head_empty;
  logic                head_pop;

  assign accept = push && !full;

  stok_front #(.P(POSITION_BITS), .L(LINE_BITS), .I(INDENT_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_value   (byte_value),
    .end_of_text  (end_of_text),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  stok_queue #(.W(BUNDLE_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (bundle_valid),
    .wr_data (bundle),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  stok_back #(.P(POSITION_BITS), .L(LINE_BITS), .I(INDENT_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_empty   (head_empty),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .line_number  (line_number),
    .indent       (indent),
    .start_offset (start_offset),
    .text_length  (text_length),
    .char_value   (char_value),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== rtl/stok_front.sv =====
// Front end of the source tokenizer: scan state and byte classification.
// Turns one accepted byte into a bundle of up to three results. Uses stok_pkg.
module stok_front
  import stok_pkg::*;
#(
  parameter int P = 20,
  parameter int L = 16,
  parameter int I = 8,
  localparam int REC_W = KIND_W + L + I + 2 * P + BYTE_W + ERR_W,
  localparam int BUNDLE_W = COUNT_W + MAX_RESULTS * REC_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [BYTE_W-1:0]   byte_value,
  input  logic                end_of_text,
  output logic                bundle_valid,
  output logic [BUNDLE_W-1:0] bundle
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [L-1:0]      line;
    logic [I-1:0]      ind;
    logic [P-1:0]      start;
    logic [P-1:0]      len;
    logic [BYTE_W-1:0] chv;
    logic [ERR_W-1:0]  err;
  } rec_t;

  localparam logic [P-1:0] POS_MAX  = {P{1'b1}};
  localparam logic [L-1:0] LINE_MAX = {L{1'b1}};
  localparam logic [I-1:0] IND_MAX  = {I{1'b1}};

  mode_t             mode, mode_next;
  logic [BYTE_W-1:0] pend, pend_next;
  logic              saw_dot, saw_dot_next;
  logic [P-1:0]      pos, pos_next;
  logic [P-1:0]      tstart, tstart_next;
  logic [L-1:0]      tline, tline_next;
  logic [L-1:0]      cline, cline_next;
  logic [I-1:0]      indent, indent_next;
  logic              at_ls, at_ls_next;
  logic [BYTE_W-1:0] held, held_next;
  logic              seen, seen_next;

  rec_t [MAX_RESULTS-1:0] res;
  logic [COUNT_W-1:0]     cnt;

  function automatic rec_t mk(input logic [KIND_W-1:0] kind, input logic [L-1:0] line,
                              input logic [I-1:0] ind, input logic [P-1:0] start,
                              input logic [P-1:0] len, input logic [BYTE_W-1:0] chv,
                              input logic [ERR_W-1:0] err);
    rec_t r;
    r.kind  = kind;
    r.line  = line;
    r.ind   = ind;
    r.start = start;
    r.len   = len;
    r.chv   = chv;
    r.err   = err;
    return r;
  endfunction

  function automatic logic [P-1:0] span(input logic [P:0] e, input logic [P-1:0] s);
    logic [P:0] d;
    d = e - {1'b0, s};
    return (e > {1'b0, s}) ? d[P-1:0] : '0;
  endfunction

  always_comb begin
    logic [3:0]        sv;
    rec_t [3:0]        slot;
    logic              used;
    logic [KIND_W-1:0] opk;
    logic [KIND_W-1:0] pk;
    logic [P:0]        pos1;
    logic [P-1:0]      pos1_sat;
    logic [L-1:0]      eline;
    logic [P-1:0]      one;
    logic [P-1:0]      two;
    mode_next    = mode;
    pend_next    = pend;
    saw_dot_next = saw_dot;
    tstart_next  = tstart;
    tline_next   = tline;
    cline_next   = cline;
    indent_next  = indent;
    at_ls_next   = at_ls;
    held_next    = held;
    seen_next    = seen;
    pos_next     = pos;
    sv           = '0;
    slot         = '0;
    used         = 1'b1;
    opk          = op_kind(pend);
    pk           = punct_kind(byte_value);
    pos1         = {1'b0, pos} + {{P{1'b0}}, 1'b1};
    pos1_sat     = (pos == POS_MAX) ? POS_MAX : pos1[P-1:0];
    eline        = '0;
    one          = {{(P-1){1'b0}}, 1'b1};
    two          = {{(P-2){1'b0}}, 2'd2};
    res          = '0;
    cnt          = '0;

    unique case (mode)
      M_DRAIN: begin
      end
      M_NUM: begin
        if (is_numeral(byte_value) || byte_value == CH_DOT) begin
          if (byte_value == CH_DOT) saw_dot_next = 1'b1;
        end else begin
          sv[0] = 1'b1;
          slot[0] = mk(saw_dot ? K_FLOAT : K_NUMBER, cline, indent, tstart,
                       span({1'b0, pos}, tstart), '0, ERR_NONE);
          seen_next = 1'b1;
          mode_next = M_IDLE;
          used = 1'b0;
        end
      end
      M_IDENT: begin
        if (!is_letter(byte_value)) begin
          sv[0] = 1'b1;
          slot[0] = mk(K_IDENT, cline, indent, tstart, span({1'b0, pos}, tstart), '0,
                       ERR_NONE);
          seen_next = 1'b1;
          mode_next = M_IDLE;
          used = 1'b0;
        end
      end
      M_OP: begin
        mode_next = M_IDLE;
        sv[0] = 1'b1;
        seen_next = 1'b1;
        if (byte_value == CH_EQ) begin
          slot[0] = mk((pend == CH_MINUS) ? K_MINUS_EQ : opk + 6'd1, cline, indent, tstart,
                       two, '0, ERR_NONE);
        end else if (pend == CH_MINUS && byte_value == CH_GT) begin
          slot[0] = mk(K_ARROW, cline, indent, tstart, two, '0, ERR_NONE);
        end else begin
          slot[0] = mk(opk, cline, indent, tstart, one, '0, ERR_NONE);
          used = 1'b0;
        end
      end
      M_CHAR_BODY: begin
        held_next = byte_value;
        mode_next = M_CHAR_CLOSE;
      end
      M_CHAR_CLOSE: begin
        sv[0] = 1'b1;
        if (byte_value == CH_SQ) begin
          slot[0] = mk(K_CHAR, cline, indent, tstart, one, held, ERR_NONE);
          seen_next = 1'b1;
          mode_next = M_IDLE;
        end else begin
          slot[0] = mk(K_NONE, cline, indent, pos, '0, '0, ERR_QUOTE);
          mode_next = M_DRAIN;
        end
      end
      M_STR: begin
        if (byte_value == CH_DQ) begin
          sv[0] = 1'b1;
          slot[0] = mk(K_STRING, cline, indent, tstart, span({1'b0, pos}, tstart), '0,
                       ERR_NONE);
          seen_next = 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (byte_value == CH_LF) begin
          mode_next = M_IDLE;
          used = 1'b0;
        end
      end
      default: begin
        mode_next = M_IDLE;
        used = 1'b0;
      end
    endcase

    if (!used && byte_value != CH_NUL) begin
      if (is_ws(byte_value)) begin
        if (byte_value == CH_LF) begin
          if (cline != LINE_MAX) cline_next = cline + 1'b1;
          indent_next = '0;
          at_ls_next = 1'b1;
        end else if (at_ls && indent != IND_MAX) begin
          indent_next = indent + 1'b1;
        end
      end else begin
        at_ls_next = 1'b0;
        if (is_numeral(byte_value)) begin
          mode_next = M_NUM;
          tstart_next = pos;
          tline_next = cline;
          saw_dot_next = 1'b0;
        end else if (is_letter(byte_value)) begin
          mode_next = M_IDENT;
          tstart_next = pos;
          tline_next = cline;
        end else if (op_kind(byte_value) != K_NONE) begin
          mode_next = M_OP;
          tstart_next = pos;
          tline_next = cline;
          pend_next = byte_value;
        end else if (byte_value == CH_SQ) begin
          mode_next = M_CHAR_BODY;
          tstart_next = pos1_sat;
          tline_next = cline;
        end else if (byte_value == CH_DQ) begin
          mode_next = M_STR;
          tstart_next = pos1_sat;
          tline_next = cline;
        end else if (byte_value == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (pk != K_NONE) begin
          tline_next = cline;
          sv[1] = 1'b1;
          slot[1] = mk(pk, cline, indent, pos, one, '0, ERR_NONE);
          seen_next = 1'b1;
        end else begin
          sv[1] = 1'b1;
          slot[1] = mk(K_NONE, cline, indent, pos, '0, '0, ERR_CHAR);
          mode_next = M_DRAIN;
        end
      end
    end

    if (end_of_text) begin
      unique case (mode_next)
        M_NUM: begin
          sv[2] = 1'b1;
          slot[2] = mk(saw_dot_next ? K_FLOAT : K_NUMBER, cline, indent, tstart_next,
                       span(pos1, tstart_next), '0, ERR_NONE);
          seen_next = 1'b1;
        end
        M_IDENT: begin
          sv[2] = 1'b1;
          slot[2] = mk(K_IDENT, cline, indent, tstart_next, span(pos1, tstart_next), '0,
                       ERR_NONE);
          seen_next = 1'b1;
        end
        M_OP: begin
          sv[2] = 1'b1;
          slot[2] = mk(op_kind(pend_next), cline, indent, tstart_next, one, '0, ERR_NONE);
          seen_next = 1'b1;
        end
        M_CHAR_BODY, M_CHAR_CLOSE: begin
          sv[2] = 1'b1;
          slot[2] = mk(K_NONE, cline, indent, pos, '0, '0, ERR_QUOTE);
          mode_next = M_DRAIN;
        end
        M_STR: begin
          sv[2] = 1'b1;
          slot[2] = mk(K_NONE, cline, indent, pos, '0, '0, ERR_STRING);
          mode_next = M_DRAIN;
        end
        default: begin
        end
      endcase
      if (mode_next != M_DRAIN) begin
        if (seen_next) eline = (tline_next == LINE_MAX) ? LINE_MAX : tline_next + 1'b1;
        sv[3] = 1'b1;
        slot[3] = mk(K_END, eline, '0, pos1_sat, '0, '0, ERR_NONE);
      end
      mode_next    = M_IDLE;
      pend_next    = '0;
      saw_dot_next = 1'b0;
      pos_next     = '0;
      tstart_next  = '0;
      tline_next   = {{(L-1){1'b0}}, 1'b1};
      cline_next   = {{(L-1){1'b0}}, 1'b1};
      indent_next  = '0;
      at_ls_next   = 1'b1;
      held_next    = '0;
      seen_next    = 1'b0;
    end else if (pos != POS_MAX) begin
      pos_next = pos1[P-1:0];
    end

    for (int k = 0; k < 4; k++) begin
      if (sv[k] && cnt != COUNT_W'(MAX_RESULTS)) begin
        res[cnt] = slot[k];
        cnt = cnt + 1'b1;
      end
    end
  end

  assign bundle_valid = accept && (cnt != '0);
  assign bundle = {cnt, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      pend    <= '0;
      saw_dot <= 1'b0;
      pos     <= '0;
      tstart  <= '0;
      tline   <= {{(L-1){1'b0}}, 1'b1};
      cline   <= {{(L-1){1'b0}}, 1'b1};
      indent  <= '0;
      at_ls   <= 1'b1;
      held    <= '0;
      seen    <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      pend    <= pend_next;
      saw_dot <= saw_dot_next;
      pos     <= pos_next;
      tstart  <= tstart_next;
      tline   <= tline_next;
      cline   <= cline_next;
      indent  <= indent_next;
      at_ls   <= at_ls_next;
      held    <= held_next;
      seen    <= seen_next;
    end
  end

endmodule

// ===== rtl/stok_queue.sv =====
// Short queue of result bundles between the tokenizer front and back ends.
// Register storage, read combinationally at the head. Uses stok_pkg.
module stok_queue
  import stok_pkg::*;
#(
  parameter int W = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/stok_back.sv =====
// Back end of the source tokenizer: walks the head bundle of the queue and
// presents its results one per transfer. Uses stok_pkg.
module stok_back
  import stok_pkg::*;
#(
  parameter int P = 20,
  parameter int L = 16,
  parameter int I = 8,
  localparam int REC_W = KIND_W + L + I + 2 * P + BYTE_W + ERR_W,
  localparam int BUNDLE_W = COUNT_W + MAX_RESULTS * REC_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [BUNDLE_W-1:0] head,
  input  logic                head_empty,
  output logic                head_pop,
  input  logic                pop,
  output logic                empty,
  output logic [KIND_W-1:0]   token_kind,
  output logic [L-1:0]        line_number,
  output logic [I-1:0]        indent,
  output logic [P-1:0]        start_offset,
  output logic [P-1:0]        text_length,
  output logic [BYTE_W-1:0]   char_value,
  output logic [ERR_W-1:0]    error_code,
  output logic                last_of_run
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [L-1:0]      line;
    logic [I-1:0]      ind;
    logic [P-1:0]      start;
    logic [P-1:0]      len;
    logic [BYTE_W-1:0] chv;
    logic [ERR_W-1:0]  err;
  } rec_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     cnt;
    rec_t [MAX_RESULTS-1:0] res;
  } bundle_t;

  bundle_t            b;
  rec_t               r;
  logic [COUNT_W-1:0] idx;
  logic               xfer;

  assign b            = bundle_t'(head);
  assign r            = b.res[idx];
  assign empty        = head_empty;
  assign last_of_run  = (idx == b.cnt - 1'b1);
  assign xfer         = pop && !head_empty;
  assign head_pop     = xfer && last_of_run;
  assign token_kind   = r.kind;
  assign line_number  = r.line;
  assign indent       = r.ind;
  assign start_offset = r.start;
  assign text_length  = r.len;
  assign char_value   = r.chv;
  assign error_code   = r.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= last_of_run ? '0 : idx + 1'b1;
    end
  end

endmodule
